@@ rtl/smx_pkg.sv @@
`default_nettype none
package smx_pkg;

   localparam int WORD_W          = 64;
   localparam int CODE_SIZE_W     = 17;
   localparam int STACK_DEPTH_DEF = 512;
   localparam int REQ_W           = 72;

   localparam logic [CODE_SIZE_W-1:0] CODE_SIZE_RESET = 17'd65536;
   localparam logic [CODE_SIZE_W-1:0] CODE_TAIL       = 17'd9;
   localparam logic [WORD_W-1:0]      IMM_ADVANCE     = 64'd9;

   localparam logic [1:0] FIN_RUN   = 2'd0;
   localparam logic [1:0] FIN_HALT  = 2'd1;
   localparam logic [1:0] FIN_BOUND = 2'd2;

   localparam logic [4:0] OP_ADD    = 5'd0;
   localparam logic [4:0] OP_SUB    = 5'd1;
   localparam logic [4:0] OP_MUL    = 5'd2;
   localparam logic [4:0] OP_DIV    = 5'd3;
   localparam logic [4:0] OP_MOD    = 5'd4;
   localparam logic [4:0] OP_AND    = 5'd5;
   localparam logic [4:0] OP_OR     = 5'd6;
   localparam logic [4:0] OP_XOR    = 5'd7;
   localparam logic [4:0] OP_NOT    = 5'd8;
   localparam logic [4:0] OP_FLIP   = 5'd9;
   localparam logic [4:0] OP_SHL    = 5'd10;
   localparam logic [4:0] OP_SHR    = 5'd11;
   localparam logic [4:0] OP_LOG2   = 5'd12;
   localparam logic [4:0] OP_GT     = 5'd13;
   localparam logic [4:0] OP_LT     = 5'd14;
   localparam logic [4:0] OP_GTE    = 5'd15;
   localparam logic [4:0] OP_LTE    = 5'd16;
   localparam logic [4:0] OP_EQ     = 5'd17;
   localparam logic [4:0] OP_NE     = 5'd18;
   localparam logic [4:0] OP_JUMP   = 5'd19;
   localparam logic [4:0] OP_BRANCH = 5'd20;
   localparam logic [4:0] OP_DUP    = 5'd21;
   localparam logic [4:0] OP_POP    = 5'd22;
   localparam logic [4:0] OP_SWAP   = 5'd23;
   localparam logic [4:0] OP_YANK   = 5'd24;
   localparam logic [4:0] OP_SHOVE  = 5'd25;
   localparam logic [4:0] OP_NOP_LO = 5'd26;
   localparam logic [4:0] OP_PUSH   = 5'd30;
   localparam logic [4:0] OP_HALT   = 5'd31;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LDA, ST_LDB, ST_MUL, ST_DIV, ST_LOG, ST_WRES,
      ST_XT0, ST_XT1, ST_SW2, ST_SW3, ST_MVRD, ST_MVWR,
      ST_RDTOP, ST_TOPQ, ST_OUT
   } state_type;

   function automatic logic need_one(input logic [4:0] op);
      return (op == OP_NOT) || (op == OP_FLIP) || (op == OP_LOG2) ||
             (op == OP_JUMP) || (op == OP_DUP) || (op == OP_POP);
   endfunction

   function automatic logic need_three(input logic [4:0] op);
      return (op == OP_SWAP) || (op == OP_YANK) || (op == OP_SHOVE);
   endfunction

endpackage
`default_nettype wire

@@ rtl/stack_machine_executor_top.sv @@
`default_nettype none
// Push, no-op, halt, bound and underfill go from the request beat through ST_RDTOP and
// ST_TOPQ to ST_OUT; unary ops first read the operand (log2 then shifts once per result
// bit), binary ops both; mul, and div/mod by non-zero, add one bit per cycle in the shared
// adder. Swap, yank and shove add the index modulo and entry moves (single read port).
// One instruction at a time: the next request is taken after the result beat.
// Reset (synchronous): pointer and depth cleared, code_size 65536; stack contents undefined.
module stack_machine_executor_top #(
   parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // instruction_byte[7:0], immediate_value[71:8]
   input  wire logic [smx_pkg::REQ_W-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // next_pointer, finish_code, depth_now, top_word (lowest first)
   output logic [((2*smx_pkg::WORD_W+2+$clog2(STACK_DEPTH+1)+7)/8)*8-1:0] rsp_tdata,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [smx_pkg::CODE_SIZE_W-1:0] csr_data
);

   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int CW    = $clog2(STACK_DEPTH + 1);
   localparam int RSP_W = ((2*smx_pkg::WORD_W + 2 + CW + 7) / 8) * 8;

   smx_pkg::state_type state_ff, state_in;
   logic [63:0] ptr_ff, ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [smx_pkg::CODE_SIZE_W-1:0] code_size_ff, code_size_in;
   logic [1:0] fin_ff, fin_in;
   logic [4:0] op_ff, op_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, rem_ff, rem_in, t_ff, t_in, top_ff, top_in;
   logic [5:0] iter_ff, iter_in;
   logic [AW-1:0] idx_ff, idx_in, j_ff, j_in, end_ff, end_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, mem_q;

   logic [65:0] alu_x, alu_y, alu_sum;
   logic        alu_cin;

   logic [4:0]    req_op;
   logic [63:0]   req_imm, ptr_inc1, shl_res, shr_res, rem_next;
   logic [64:0]   div_x;
   logic          div_ge;
   logic [AW-1:0] top_idx, sec_idx, cnt_idx;
   logic          cnt_room, out_of_code;

   smx_stack_ram #(.DEPTH(STACK_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   assign alu_sum = alu_x + alu_y + {65'd0, alu_cin};

   assign req_op   = req_tdata[4:0];
   assign req_imm  = req_tdata[71:8];
   assign ptr_inc1 = ptr_ff + 64'd1;
   assign top_idx  = AW'(cnt_ff - CW'(1));
   assign sec_idx  = AW'(cnt_ff - CW'(2));
   assign cnt_idx  = AW'(cnt_ff);
   assign cnt_room = cnt_ff < CW'(STACK_DEPTH);
   assign out_of_code = (code_size_ff >= smx_pkg::CODE_TAIL) &&
                        (ptr_ff > {47'd0, code_size_ff - smx_pkg::CODE_TAIL});
   assign shl_res  = (mem_q[63:6] != 58'd0) ? 64'd0 : (a_ff << mem_q[5:0]);
   assign shr_res  = (mem_q[63:6] != 58'd0) ? 64'd0 : (a_ff >> mem_q[5:0]);
   assign div_x    = {rem_ff, a_ff[63]};
   assign div_ge   = ~alu_sum[65];
   assign rem_next = div_ge ? alu_sum[63:0] : div_x[63:0];

   assign req_tready = (state_ff == smx_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == smx_pkg::ST_OUT);
   assign rsp_tdata  = RSP_W'({top_ff, cnt_ff, fin_ff, ptr_ff});
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      code_size_in = csr_valid ? csr_data : code_size_ff;
      fin_in = fin_ff;
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      rem_in = rem_ff;
      t_in = t_ff;
      top_in = top_ff;
      iter_in = iter_ff;
      idx_in = idx_ff;
      j_in = j_ff;
      end_in = end_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_addr = '0;
      alu_x = '0;
      alu_y = '0;
      alu_cin = 1'b0;
      unique case (state_ff)
         smx_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in = req_op;
               fin_in = smx_pkg::FIN_RUN;
               state_in = smx_pkg::ST_RDTOP;
               if (out_of_code) begin
                  fin_in = smx_pkg::FIN_BOUND;
               end else if (req_op == smx_pkg::OP_HALT) begin
                  fin_in = smx_pkg::FIN_HALT;
               end else if (req_op == smx_pkg::OP_PUSH) begin
                  ptr_in = ptr_ff + smx_pkg::IMM_ADVANCE;
                  if (cnt_room) begin
                     wr_en = 1'b1;
                     wr_addr = cnt_idx;
                     wr_data = req_imm;
                     cnt_in = cnt_ff + CW'(1);
                  end
               end else if (req_op >= smx_pkg::OP_NOP_LO) begin
                  ptr_in = ptr_inc1;
               end else if ((smx_pkg::need_one(req_op) && cnt_ff < CW'(1)) ||
                            (smx_pkg::need_three(req_op) && cnt_ff < CW'(3)) ||
                            (!smx_pkg::need_one(req_op) && !smx_pkg::need_three(req_op) &&
                             cnt_ff < CW'(2))) begin
                  if (req_op != smx_pkg::OP_BRANCH) begin
                     ptr_in = ptr_inc1;
                  end
               end else begin
                  rd_addr = top_idx;
                  state_in = smx_pkg::ST_LDA;
               end
            end
         end
         smx_pkg::ST_LDA: begin
            state_in = smx_pkg::ST_RDTOP;
            if (smx_pkg::need_one(op_ff)) begin
               ptr_in = ptr_inc1;
               unique case (op_ff)
                  smx_pkg::OP_NOT: begin
                     wr_en = 1'b1;
                     wr_addr = top_idx;
                     wr_data = {63'd0, mem_q == 64'd0};
                  end
                  smx_pkg::OP_FLIP: begin
                     wr_en = 1'b1;
                     wr_addr = top_idx;
                     wr_data = ~mem_q;
                  end
                  smx_pkg::OP_LOG2: begin
                     a_in = mem_q | 64'd1;
                     rem_in = '0;
                     state_in = smx_pkg::ST_LOG;
                  end
                  smx_pkg::OP_JUMP: begin
                     ptr_in = mem_q + 64'd1;
                     cnt_in = cnt_ff - CW'(1);
                  end
                  smx_pkg::OP_DUP: begin
                     if (cnt_room) begin
                        wr_en = 1'b1;
                        wr_addr = cnt_idx;
                        wr_data = mem_q;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  default: begin
                     cnt_in = cnt_ff - CW'(1);
                  end
               endcase
            end else if (smx_pkg::need_three(op_ff)) begin
               ptr_in = ptr_inc1;
               cnt_in = cnt_ff - CW'(1);
               a_in = mem_q;
               b_in = 64'(cnt_ff - CW'(1));
               rem_in = '0;
               iter_in = '1;
               state_in = smx_pkg::ST_DIV;
            end else begin
               a_in = mem_q;
               rd_addr = sec_idx;
               state_in = smx_pkg::ST_LDB;
            end
         end
         smx_pkg::ST_LDB: begin
            ptr_in = ptr_inc1;
            cnt_in = cnt_ff - CW'(1);
            wr_en = 1'b1;
            wr_addr = sec_idx;
            alu_x = {2'd0, a_ff};
            alu_y = {2'd0, mem_q};
            state_in = smx_pkg::ST_RDTOP;
            unique case (op_ff)
               smx_pkg::OP_ADD: wr_data = alu_sum[63:0];
               smx_pkg::OP_SUB: begin
                  alu_y = ~{2'd0, mem_q};
                  alu_cin = 1'b1;
                  wr_data = alu_sum[63:0];
               end
               smx_pkg::OP_AND: wr_data = a_ff & mem_q;
               smx_pkg::OP_OR:  wr_data = a_ff | mem_q;
               smx_pkg::OP_XOR: wr_data = a_ff ^ mem_q;
               smx_pkg::OP_SHL: wr_data = shl_res;
               smx_pkg::OP_SHR: wr_data = shr_res;
               smx_pkg::OP_GT:  wr_data = {63'd0, a_ff > mem_q};
               smx_pkg::OP_LT:  wr_data = {63'd0, a_ff < mem_q};
               smx_pkg::OP_GTE: wr_data = {63'd0, a_ff >= mem_q};
               smx_pkg::OP_LTE: wr_data = {63'd0, a_ff <= mem_q};
               smx_pkg::OP_EQ:  wr_data = {63'd0, a_ff == mem_q};
               smx_pkg::OP_NE:  wr_data = {63'd0, a_ff != mem_q};
               smx_pkg::OP_MUL: begin
                  wr_en = 1'b0;
                  cnt_in = cnt_ff;
                  b_in = mem_q;
                  rem_in = '0;
                  iter_in = '1;
                  state_in = smx_pkg::ST_MUL;
               end
               smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
                  wr_en = 1'b0;
                  if (mem_q == 64'd0) begin
                     cnt_in = cnt_ff - CW'(2);
                  end else begin
                     cnt_in = cnt_ff;
                     b_in = mem_q;
                     rem_in = '0;
                     iter_in = '1;
                     state_in = smx_pkg::ST_DIV;
                  end
               end
               smx_pkg::OP_BRANCH: begin
                  wr_en = 1'b0;
                  cnt_in = cnt_ff - CW'(2);
                  if (a_ff == 64'd0) begin
                     ptr_in = mem_q;
                  end
               end
               default: wr_en = 1'b0;
            endcase
         end
         smx_pkg::ST_MUL: begin
            alu_x = {2'd0, rem_ff};
            alu_y = {2'd0, a_ff};
            if (b_ff[0]) begin
               rem_in = alu_sum[63:0];
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               state_in = smx_pkg::ST_WRES;
            end
         end
         smx_pkg::ST_DIV: begin
            alu_x = {1'b0, div_x};
            alu_y = ~{2'd0, b_ff};
            alu_cin = 1'b1;
            rem_in = rem_next;
            a_in = {a_ff[62:0], div_ge};
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               if (smx_pkg::need_three(op_ff)) begin
                  idx_in = rem_next[AW-1:0];
                  state_in = smx_pkg::ST_XT0;
               end else begin
                  state_in = smx_pkg::ST_WRES;
               end
            end
         end
         smx_pkg::ST_LOG: begin
            if (a_ff[63:1] != 63'd0) begin
               a_in = a_ff >> 1;
               rem_in = rem_ff + 64'd1;
            end else begin
               wr_en = 1'b1;
               wr_addr = top_idx;
               wr_data = rem_ff;
               state_in = smx_pkg::ST_RDTOP;
            end
         end
         smx_pkg::ST_WRES: begin
            wr_en = 1'b1;
            wr_addr = sec_idx;
            wr_data = (op_ff == smx_pkg::OP_DIV) ? a_ff : rem_ff;
            cnt_in = cnt_ff - CW'(1);
            state_in = smx_pkg::ST_RDTOP;
         end
         smx_pkg::ST_XT0: begin
            rd_addr = (op_ff == smx_pkg::OP_SHOVE) ? top_idx : idx_ff;
            state_in = smx_pkg::ST_XT1;
         end
         smx_pkg::ST_XT1: begin
            t_in = mem_q;
            if (op_ff == smx_pkg::OP_SWAP) begin
               rd_addr = top_idx;
               state_in = smx_pkg::ST_SW2;
            end else if (op_ff == smx_pkg::OP_YANK) begin
               j_in = idx_ff;
               end_in = top_idx;
               state_in = smx_pkg::ST_MVRD;
            end else begin
               j_in = top_idx;
               end_in = idx_ff;
               state_in = smx_pkg::ST_MVRD;
            end
         end
         smx_pkg::ST_SW2: begin
            wr_en = 1'b1;
            wr_addr = idx_ff;
            wr_data = mem_q;
            state_in = smx_pkg::ST_SW3;
         end
         smx_pkg::ST_SW3: begin
            wr_en = 1'b1;
            wr_addr = top_idx;
            wr_data = t_ff;
            state_in = smx_pkg::ST_RDTOP;
         end
         smx_pkg::ST_MVRD: begin
            if (j_ff == end_ff) begin
               wr_en = 1'b1;
               wr_addr = end_ff;
               wr_data = t_ff;
               state_in = smx_pkg::ST_RDTOP;
            end else begin
               rd_addr = (op_ff == smx_pkg::OP_YANK) ? j_ff + AW'(1) : j_ff - AW'(1);
               state_in = smx_pkg::ST_MVWR;
            end
         end
         smx_pkg::ST_MVWR: begin
            wr_en = 1'b1;
            wr_addr = j_ff;
            wr_data = mem_q;
            j_in = (op_ff == smx_pkg::OP_YANK) ? j_ff + AW'(1) : j_ff - AW'(1);
            state_in = smx_pkg::ST_MVRD;
         end
         smx_pkg::ST_RDTOP: begin
            rd_addr = top_idx;
            state_in = smx_pkg::ST_TOPQ;
         end
         smx_pkg::ST_TOPQ: begin
            top_in = (cnt_ff != '0) ? mem_q : 64'd0;
            state_in = smx_pkg::ST_OUT;
         end
         smx_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = smx_pkg::ST_IDLE;
            end
         end
         default: state_in = smx_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smx_pkg::ST_IDLE;
         ptr_ff <= '0;
         cnt_ff <= '0;
         code_size_ff <= smx_pkg::CODE_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
         code_size_ff <= code_size_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      op_ff <= op_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rem_ff <= rem_in;
      t_ff <= t_in;
      top_ff <= top_in;
      iter_ff <= iter_in;
      idx_ff <= idx_in;
      j_ff <= j_in;
      end_ff <= end_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == smx_pkg::ST_XT0 |-> CW'(idx_ff) < cnt_ff)
      else $error("stack index not below depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fin_ff == smx_pkg::FIN_RUN || fin_ff == smx_pkg::FIN_HALT ||
                      fin_ff == smx_pkg::FIN_BOUND))
      else $error("bad finish code");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == smx_pkg::ST_OUT && rsp_tready |=> req_tready && !rsp_tvalid)
      else $error("no return to idle after result beat");

endmodule
`default_nettype wire

@@ rtl/smx_stack_ram.sv @@
`default_nettype none
module smx_stack_ram #(
   parameter int DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire logic [smx_pkg::WORD_W-1:0]  wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic      [smx_pkg::WORD_W-1:0]  rd_data
);

   logic [smx_pkg::WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ dv/smx_checker.sv @@
`default_nettype none
module smx_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   input  wire logic req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic [143:0] rsp_tdata,
   input  wire logic csr_valid,
   input  wire logic csr_ready,
   input  wire logic [16:0] csr_data,
   output int fail_count,
   output int pending_count
);

   typedef struct packed {
      logic [63:0] top;
      logic [9:0]  depth;
      logic [1:0]  fin;
      logic [63:0] ptr;
   } step_result_type;

   localparam int DEPTH = smx_pkg::STACK_DEPTH_DEF;

   logic [63:0] mdl_stack [DEPTH];
   int unsigned mdl_count;
   logic [63:0] mdl_ptr;
   logic [16:0] mdl_code_size;
   step_result_type result_queue[$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   function automatic void push_word(input logic [63:0] v);
      if (mdl_count < DEPTH) begin
         mdl_stack[mdl_count] = v;
         mdl_count++;
      end
   endfunction

   function automatic logic [63:0] pop_word();
      if (mdl_count == 0) return 64'd0;
      mdl_count--;
      return mdl_stack[mdl_count];
   endfunction

   function automatic logic [63:0] highest_bit(input logic [63:0] a);
      logic [63:0] n;
      n = 64'd0;
      for (int k = 0; k < 64; k++)
         if ((a | 64'd1) >> k != 0) n = 64'(k);
      return n;
   endfunction

   function automatic step_result_type execute_instruction(input logic [7:0] ib,
                                                           input logic [63:0] imm);
      logic [4:0] op;
      logic [63:0] p, a, b, t;
      logic [1:0] fin;
      int unsigned need, n, i;
      step_result_type r;
      op = ib[4:0];
      p = mdl_ptr;
      fin = smx_pkg::FIN_RUN;
      need = 2;
      if (mdl_code_size >= 17'd9 && p > 64'(mdl_code_size) - 64'd9) begin
         fin = smx_pkg::FIN_BOUND;
      end else if (op == smx_pkg::OP_HALT) begin
         fin = smx_pkg::FIN_HALT;
      end else if (op == smx_pkg::OP_PUSH) begin
         push_word(imm);
         p += 64'd9;
      end else if (op >= smx_pkg::OP_NOP_LO) begin
         p += 64'd1;
      end else begin
         if (smx_pkg::need_one(op)) need = 1;
         else if (smx_pkg::need_three(op)) need = 3;
         if (mdl_count < need) begin
            if (op != smx_pkg::OP_BRANCH) p += 64'd1;
         end else if (need == 1) begin
            a = pop_word();
            p += 64'd1;
            case (op)
               smx_pkg::OP_NOT: push_word(a == 0 ? 64'd1 : 64'd0);
               smx_pkg::OP_FLIP: push_word(~a);
               smx_pkg::OP_LOG2: push_word(highest_bit(a));
               smx_pkg::OP_JUMP: p = a + 64'd1;
               smx_pkg::OP_DUP: begin
                  push_word(a);
                  push_word(a);
               end
               default: ;
            endcase
         end else if (need == 3) begin
            a = pop_word();
            n = mdl_count;
            i = int'(a % 64'(n));
            t = mdl_stack[n-1];
            if (op == smx_pkg::OP_SWAP) begin
               mdl_stack[n-1] = mdl_stack[i];
               mdl_stack[i] = t;
            end else if (op == smx_pkg::OP_YANK) begin
               t = mdl_stack[i];
               for (int k = i; k < n - 1; k++) mdl_stack[k] = mdl_stack[k+1];
               mdl_stack[n-1] = t;
            end else begin
               for (int k = n - 1; k > i; k--) mdl_stack[k] = mdl_stack[k-1];
               mdl_stack[i] = t;
            end
            p += 64'd1;
         end else begin
            a = pop_word();
            b = pop_word();
            p += 64'd1;
            case (op)
               smx_pkg::OP_ADD: push_word(a + b);
               smx_pkg::OP_SUB: push_word(a - b);
               smx_pkg::OP_MUL: push_word(a * b);
               smx_pkg::OP_DIV: if (b != 0) push_word(a / b);
               smx_pkg::OP_MOD: if (b != 0) push_word(a % b);
               smx_pkg::OP_AND: push_word(a & b);
               smx_pkg::OP_OR: push_word(a | b);
               smx_pkg::OP_XOR: push_word(a ^ b);
               smx_pkg::OP_SHL: push_word(b >= 64 ? 64'd0 : a << b);
               smx_pkg::OP_SHR: push_word(b >= 64 ? 64'd0 : a >> b);
               smx_pkg::OP_GT: push_word(64'(a > b));
               smx_pkg::OP_LT: push_word(64'(a < b));
               smx_pkg::OP_GTE: push_word(64'(a >= b));
               smx_pkg::OP_LTE: push_word(64'(a <= b));
               smx_pkg::OP_EQ: push_word(64'(a == b));
               smx_pkg::OP_NE: push_word(64'(a != b));
               smx_pkg::OP_BRANCH: if (a == 0) p = b;
               default: ;
            endcase
         end
      end
      mdl_ptr = p;
      r.ptr = p;
      r.fin = fin;
      r.depth = 10'(mdl_count);
      r.top = mdl_count != 0 ? mdl_stack[mdl_count-1] : 64'd0;
      return r;
   endfunction

   always @(posedge clock) begin
      step_result_type want, got;
      if (reset) begin
         mdl_ptr = 0;
         mdl_count = 0;
         mdl_code_size = smx_pkg::CODE_SIZE_RESET;
         result_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) mdl_code_size = csr_data;
         if (req_tvalid && req_tready)
            result_queue.push_back(execute_instruction(req_tdata[7:0], req_tdata[71:8]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[139:0];
            if (result_queue.size() == 0) begin
               report_mismatch("unexpected beat", got.ptr, 64'd0);
            end else begin
               want = result_queue.pop_front();
               if (got.ptr !== want.ptr) report_mismatch("next_pointer", got.ptr, want.ptr);
               if (got.fin !== want.fin) report_mismatch("finish_code", 64'(got.fin), 64'(want.fin));
               if (got.depth !== want.depth)
                  report_mismatch("depth_now", 64'(got.depth), 64'(want.depth));
               if (got.top !== want.top) report_mismatch("top_word", got.top, want.top);
            end
         end
      end
      pending_count = result_queue.size();
   end
endmodule
`default_nettype wire

@@ dv/tb_stack_machine_executor_top.sv @@
`default_nettype none
module tb_stack_machine_executor_top;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [71:0] req_tdata = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [143:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [16:0] csr_data = 0;
   int fail_count, pending_count;
   int cycle_count = 0;
   bit calm = 0;
   int sent = 0;

   always #5 clock = ~clock;

   stack_machine_executor_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   smx_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 10000000) begin
         $display("tb_stack_machine_executor_top failed");
         $finish;
      end
   end

   // result-side stalls in bursts
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge clock);
            rsp_tready <= 1;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // valid stays up after a beat; the next beat, an idle burst or drain() changes it
   task automatic send_beat(input logic [4:0] op, input logic [2:0] hi, input logic [63:0] imm);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         gap = $urandom_range(1, 16);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {imm, hi, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (800) @(negedge clock);
   endtask

   task automatic write_code_size(input logic [16:0] v);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return '1;
         2: return 64'($urandom_range(0, 70));
         3: return 64'h8000_0000_0000_0000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // jumps/branches would scatter the pointer; keep their targets small mostly
   task automatic random_phase(input int count);
      logic [4:0] op;
      for (int k = 0; k < count; k++) begin
         op = 5'($urandom_range(0, 31));
         if ($urandom_range(0, 2) == 0) op = smx_pkg::OP_PUSH;
         if (op == smx_pkg::OP_HALT && $urandom_range(0, 3) != 0) op = smx_pkg::OP_NOP_LO;
         if ((op == smx_pkg::OP_JUMP || op == smx_pkg::OP_BRANCH) &&
             $urandom_range(0, 1) == 0) begin
            send_beat(smx_pkg::OP_PUSH, 3'($urandom), 64'($urandom_range(0, 200)));
            if (op == smx_pkg::OP_BRANCH)
               send_beat(smx_pkg::OP_PUSH, 3'($urandom), 64'($urandom_range(0, 1)));
         end
         send_beat(op, 3'($urandom), rand_word());
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: each opcode underflowing on an empty stack, then div, shift by 64 and halt
      for (int op = 0; op < 26; op++) send_beat(5'(op), 3'b000, 64'd0);
      send_beat(smx_pkg::OP_PUSH, 3'b111, '1);
      send_beat(smx_pkg::OP_PUSH, 3'b000, 64'd0);
      send_beat(smx_pkg::OP_DIV, 3'b101, 64'd0);
      send_beat(smx_pkg::OP_PUSH, 3'b000, 64'd64);
      send_beat(smx_pkg::OP_PUSH, 3'b000, 64'd5);
      send_beat(smx_pkg::OP_SHL, 3'b000, 64'd0);
      send_beat(smx_pkg::OP_HALT, 3'b111, 64'd0);
      send_beat(smx_pkg::OP_HALT, 3'b000, 64'd0);
      drain();
      write_code_size(17'd65536);
      // fill to overflow with pushes
      for (int k = 0; k < 520; k++) send_beat(smx_pkg::OP_PUSH, 3'($urandom), rand_word());
      send_beat(smx_pkg::OP_DUP, 3'b000, 64'd0);
      for (int k = 0; k < 6; k++)
         send_beat(5'($urandom_range(smx_pkg::OP_SWAP, smx_pkg::OP_SHOVE)), 3'b000, 64'd0);
      drain();
      write_code_size(17'd9);
      random_phase(150);
      drain();
      write_code_size(17'd0);
      random_phase(120);
      drain();
      write_code_size(17'd300);
      random_phase(150);
      drain();
      write_code_size(17'd1);
      random_phase(60);
      drain();
      write_code_size(17'd131071);
      random_phase(200);
      calm = 1;
      random_phase(100);
      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (800) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_stack_machine_executor_top passed");
      end else begin
         $display("tb_stack_machine_executor_top failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/smx_pkg.sv
rtl/smx_stack_ram.sv
rtl/stack_machine_executor_top.sv
dv/smx_checker.sv
dv/tb_stack_machine_executor_top.sv
